[src/lds_pkg.sv]
`timescale 1ns / 1ps

package lds_pkg;

    // Phase state, one-hot
    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_APPROACH = 6'b000010,
        PH_LIFT     = 6'b000100,
        PH_LOWER    = 6'b001000,
        PH_LEAVE    = 6'b010000,
        PH_CHARGE   = 6'b100000
    } phase_t;

    // Phase codes as reported on the result channel
    localparam logic [2:0] PCODE_IDLE     = 3'd0;
    localparam logic [2:0] PCODE_APPROACH = 3'd1;
    localparam logic [2:0] PCODE_LIFT     = 3'd2;
    localparam logic [2:0] PCODE_LOWER    = 3'd3;
    localparam logic [2:0] PCODE_LEAVE    = 3'd4;
    localparam logic [2:0] PCODE_CHARGE   = 3'd5;

    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [3:0] C_NONE         = 4'd0;
    localparam logic [3:0] C_MOUNT        = 4'd1;
    localparam logic [3:0] C_UNMOUNT      = 4'd2;
    localparam logic [3:0] C_TEST_UNMOUNT = 4'd3;
    localparam logic [3:0] C_REC_MOUNT    = 4'd4;
    localparam logic [3:0] C_REC_UNMOUNT  = 4'd5;
    localparam logic [3:0] C_CHG_ENTER    = 4'd6;
    localparam logic [3:0] C_CONT_BOX     = 4'd7;
    localparam logic [3:0] C_CONT_NOBOX   = 4'd8;
    localparam logic [3:0] C_CHG_LEAVE    = 4'd9;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_LIFTED      = 3'd1;
    localparam logic [2:0] EV_CHG_ENTERED = 3'd2;
    localparam logic [2:0] EV_MOUNT_DONE  = 3'd3;
    localparam logic [2:0] EV_RECOVERED   = 3'd4;
    localparam logic [2:0] EV_CHG_LEFT    = 3'd5;

    localparam logic [1:0] DIR_STOP     = 2'd0;
    localparam logic [1:0] DIR_APPROACH = 2'd1;
    localparam logic [1:0] DIR_LEAVE    = 2'd2;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_APPROACH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIFT     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEAVE    = 2'd3;

    localparam logic [CFG_BITS-1:0] TICKS_RESET = 16'd200;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:     code = PCODE_IDLE;
            PH_APPROACH: code = PCODE_APPROACH;
            PH_LIFT:     code = PCODE_LIFT;
            PH_LOWER:    code = PCODE_LOWER;
            PH_LEAVE:    code = PCODE_LEAVE;
            PH_CHARGE:   code = PCODE_CHARGE;
            default:     code = PCODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

[src/lift_dock_sequencer_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  req_type, cmd_code
// out       output     out_valid / out_stall phase, pending_cmd, carrying, event_code, drive_dir
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle when in_stall is low; the result appears in the output register
// in the cycle after acceptance. Tick, sequencer and result registers are the only storage.
// in_stall is high only while a result is held in the output register and out_stall is high.
// cfg_ready is always high. Reset sets all tick registers to 200, the phase to idle and
// clears the latched command, the counters and the carry flag.

module lift_dock_sequencer_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic [3:0]                           cmd_code,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           phase,
    output logic [3:0]                           pending_cmd,
    output logic                                 carrying,
    output logic [2:0]                           event_code,
    output logic [1:0]                           drive_dir,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lds_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lds_pkg::CFG_BITS-1:0]         cfg_data
);

    localparam int ExtBits = (COUNT_BITS > lds_pkg::CFG_BITS) ? COUNT_BITS : lds_pkg::CFG_BITS;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    // Configuration
    logic [lds_pkg::CFG_BITS-1:0] approach_ticks_reg;
    logic [lds_pkg::CFG_BITS-1:0] lift_ticks_reg;
    logic [lds_pkg::CFG_BITS-1:0] lower_ticks_reg;
    logic [lds_pkg::CFG_BITS-1:0] leave_ticks_reg;

    // Sequencer state
    lds_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      cmd_reg, cmd_next;
    logic            carry_reg, carry_next;
    cnt_t            appr_left_reg, appr_left_next;
    cnt_t            lift_left_reg, lift_left_next;
    cnt_t            lower_left_reg, lower_left_next;
    cnt_t            leave_left_reg, leave_left_next;

    // Result register
    logic            out_valid_reg;
    logic [2:0]      res_phase_reg;
    logic [3:0]      res_cmd_reg;
    logic            res_carry_reg;
    logic [2:0]      res_event_reg, event_next;
    logic [1:0]      res_dir_reg, dir_next;

    logic            in_accept;
    logic            out_accept;

    cnt_t            appr_load, lift_load, lower_load, leave_load;
    cnt_t            appr_mid, lift_mid, lower_mid, leave_mid;
    logic [ExtBits-1:0] appr_ext, lift_ext, lower_ext, leave_ext;

    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;

    // Register values cut or widened to the counter width
    assign appr_ext   = ExtBits'(approach_ticks_reg);
    assign lift_ext   = ExtBits'(lift_ticks_reg);
    assign lower_ext  = ExtBits'(lower_ticks_reg);
    assign leave_ext  = ExtBits'(leave_ticks_reg);
    assign appr_load  = appr_ext[COUNT_BITS-1:0];
    assign lift_load  = lift_ext[COUNT_BITS-1:0];
    assign lower_load = lower_ext[COUNT_BITS-1:0];
    assign leave_load = leave_ext[COUNT_BITS-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        carry_next      = carry_reg;
        appr_mid        = appr_left_reg;
        lift_mid        = lift_left_reg;
        lower_mid       = lower_left_reg;
        leave_mid       = leave_left_reg;
        appr_left_next  = appr_left_reg;
        lift_left_next  = lift_left_reg;
        lower_left_next = lower_left_reg;
        leave_left_next = leave_left_reg;
        event_next      = lds_pkg::EV_NONE;
        dir_next        = lds_pkg::DIR_STOP;

        if (req_type == lds_pkg::REQ_CMD)
        begin
            if (phase_reg == lds_pkg::PH_IDLE)
            begin
                cmd_next = cmd_code;
            end
            else if (cmd_reg == lds_pkg::C_MOUNT && cmd_code == lds_pkg::C_REC_MOUNT)
            begin
                cmd_next = cmd_code;
            end
            else if ((cmd_reg == lds_pkg::C_UNMOUNT || cmd_reg == lds_pkg::C_TEST_UNMOUNT) &&
                     cmd_code == lds_pkg::C_REC_UNMOUNT)
            begin
                cmd_next = cmd_code;
            end
            else if ((cmd_reg == lds_pkg::C_CHG_ENTER || cmd_reg == lds_pkg::C_CONT_BOX ||
                      cmd_reg == lds_pkg::C_CONT_NOBOX) && cmd_code == lds_pkg::C_CHG_LEAVE)
            begin
                cmd_next = cmd_code;
            end
        end
        else
        begin
            // Transition first
            case (phase_reg)
                lds_pkg::PH_IDLE:
                begin
                    if (cmd_reg == lds_pkg::C_MOUNT || cmd_reg == lds_pkg::C_TEST_UNMOUNT ||
                        cmd_reg == lds_pkg::C_CHG_ENTER)
                    begin
                        appr_mid   = appr_load;
                        lift_mid   = lift_load;
                        lower_mid  = lower_load;
                        leave_mid  = leave_load;
                        phase_next = lds_pkg::PH_APPROACH;
                    end
                    else if (cmd_reg == lds_pkg::C_UNMOUNT)
                    begin
                        lift_mid   = lift_load;
                        lower_mid  = lower_load;
                        leave_mid  = leave_load;
                        phase_next = lds_pkg::PH_LOWER;
                    end
                    else if (cmd_reg == lds_pkg::C_CONT_BOX || cmd_reg == lds_pkg::C_CONT_NOBOX)
                    begin
                        lift_mid   = lift_load;
                        leave_mid  = leave_load;
                        phase_next = lds_pkg::PH_CHARGE;
                    end
                end
                lds_pkg::PH_APPROACH:
                begin
                    if (cmd_reg == lds_pkg::C_MOUNT)
                    begin
                        if (appr_left_reg == '0)
                        begin
                            phase_next = lds_pkg::PH_LIFT;
                        end
                    end
                    else if (cmd_reg == lds_pkg::C_UNMOUNT ||
                             cmd_reg == lds_pkg::C_TEST_UNMOUNT ||
                             cmd_reg == lds_pkg::C_CHG_ENTER)
                    begin
                        if (appr_left_reg == '0)
                        begin
                            phase_next = lds_pkg::PH_LOWER;
                        end
                    end
                    else if (cmd_reg == lds_pkg::C_REC_MOUNT ||
                             cmd_reg == lds_pkg::C_REC_UNMOUNT)
                    begin
                        // back out over the distance already driven in
                        leave_mid  = (appr_load > appr_left_reg) ? appr_load - appr_left_reg
                                                                 : '0;
                        phase_next = lds_pkg::PH_LEAVE;
                    end
                end
                lds_pkg::PH_LIFT:
                begin
                    if (cmd_reg == lds_pkg::C_MOUNT && lift_left_reg == '0)
                    begin
                        carry_next = 1'b1;
                        phase_next = lds_pkg::PH_LEAVE;
                        event_next = lds_pkg::EV_LIFTED;
                    end
                    else if (cmd_reg == lds_pkg::C_CHG_LEAVE && lift_left_reg == '0)
                    begin
                        phase_next = lds_pkg::PH_LEAVE;
                    end
                end
                lds_pkg::PH_LOWER:
                begin
                    if ((cmd_reg == lds_pkg::C_UNMOUNT || cmd_reg == lds_pkg::C_TEST_UNMOUNT) &&
                        lower_left_reg == '0)
                    begin
                        carry_next = 1'b0;
                        phase_next = lds_pkg::PH_LEAVE;
                    end
                    else if (cmd_reg == lds_pkg::C_CHG_ENTER && lower_left_reg == '0)
                    begin
                        carry_next = 1'b0;
                        phase_next = lds_pkg::PH_CHARGE;
                        event_next = lds_pkg::EV_CHG_ENTERED;
                    end
                end
                lds_pkg::PH_CHARGE:
                begin
                    if (cmd_reg == lds_pkg::C_CHG_LEAVE)
                    begin
                        phase_next = lds_pkg::PH_LIFT;
                    end
                end
                lds_pkg::PH_LEAVE:
                begin
                    if (leave_left_reg == '0)
                    begin
                        if (cmd_reg == lds_pkg::C_MOUNT || cmd_reg == lds_pkg::C_UNMOUNT ||
                            cmd_reg == lds_pkg::C_TEST_UNMOUNT)
                        begin
                            event_next = lds_pkg::EV_MOUNT_DONE;
                        end
                        else if (cmd_reg == lds_pkg::C_REC_MOUNT ||
                                 cmd_reg == lds_pkg::C_REC_UNMOUNT)
                        begin
                            event_next = lds_pkg::EV_RECOVERED;
                        end
                        else if (cmd_reg == lds_pkg::C_CHG_LEAVE)
                        begin
                            event_next = lds_pkg::EV_CHG_LEFT;
                        end
                        if (event_next != lds_pkg::EV_NONE)
                        begin
                            phase_next = lds_pkg::PH_IDLE;
                            cmd_next   = lds_pkg::C_NONE;
                        end
                    end
                end
                default:
                begin
                    phase_next = lds_pkg::PH_IDLE;
                end
            endcase

            appr_left_next  = appr_mid;
            lift_left_next  = lift_mid;
            lower_left_next = lower_mid;
            leave_left_next = leave_mid;

            // Then count down in the new phase, holding at zero
            case (phase_next)
                lds_pkg::PH_APPROACH:
                begin
                    dir_next = lds_pkg::DIR_APPROACH;
                    if (appr_mid != '0)
                    begin
                        appr_left_next = appr_mid - cnt_t'(1);
                    end
                end
                lds_pkg::PH_LIFT:
                begin
                    if (lift_mid != '0)
                    begin
                        lift_left_next = lift_mid - cnt_t'(1);
                    end
                end
                lds_pkg::PH_LOWER:
                begin
                    if (lower_mid != '0)
                    begin
                        lower_left_next = lower_mid - cnt_t'(1);
                    end
                end
                lds_pkg::PH_LEAVE:
                begin
                    dir_next = lds_pkg::DIR_LEAVE;
                    if (leave_mid != '0)
                    begin
                        leave_left_next = leave_mid - cnt_t'(1);
                    end
                end
                default:
                begin
                    dir_next = lds_pkg::DIR_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            approach_ticks_reg <= lds_pkg::TICKS_RESET;
            lift_ticks_reg     <= lds_pkg::TICKS_RESET;
            lower_ticks_reg    <= lds_pkg::TICKS_RESET;
            leave_ticks_reg    <= lds_pkg::TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lds_pkg::REG_APPROACH: approach_ticks_reg <= cfg_data;
                lds_pkg::REG_LIFT:     lift_ticks_reg     <= cfg_data;
                lds_pkg::REG_LOWER:    lower_ticks_reg    <= cfg_data;
                lds_pkg::REG_LEAVE:    leave_ticks_reg    <= cfg_data;
                default:               approach_ticks_reg <= approach_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lds_pkg::PH_IDLE;
            cmd_reg        <= lds_pkg::C_NONE;
            carry_reg      <= 1'b0;
            appr_left_reg  <= '0;
            lift_left_reg  <= '0;
            lower_left_reg <= '0;
            leave_left_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            carry_reg      <= carry_next;
            appr_left_reg  <= appr_left_next;
            lift_left_reg  <= lift_left_next;
            lower_left_reg <= lower_left_next;
            leave_left_reg <= leave_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_phase_reg <= lds_pkg::phase_code(phase_next);
            res_cmd_reg   <= cmd_next;
            res_carry_reg <= carry_next;
            res_event_reg <= event_next;
            res_dir_reg   <= dir_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign phase       = res_phase_reg;
    assign pending_cmd = res_cmd_reg;
    assign carrying    = res_carry_reg;
    assign event_code  = res_event_reg;
    assign drive_dir   = res_dir_reg;

`ifndef NO_ASSERTIONS
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase state not one-hot");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_event_reg == lds_pkg::EV_MOUNT_DONE ||
                          res_event_reg == lds_pkg::EV_RECOVERED ||
                          res_event_reg == lds_pkg::EV_CHG_LEFT)
        |-> res_phase_reg == lds_pkg::PCODE_IDLE && res_cmd_reg == lds_pkg::C_NONE)
        else $error("completion event without return to idle");

    a_dir_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_dir_reg == lds_pkg::DIR_APPROACH
        |-> res_phase_reg == lds_pkg::PCODE_APPROACH)
        else $error("approach motion outside approach phase");

    a_lifted_carries: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_event_reg == lds_pkg::EV_LIFTED
        |-> res_carry_reg && res_phase_reg == lds_pkg::PCODE_LEAVE)
        else $error("box lifted without carry flag");
`endif

endmodule
